### design/cstp_pkg.sv
package cstp_pkg;

    localparam int STACK_DEPTH  = 1024;
    localparam int RECORD_SLOTS = 256;
    localparam int TIME_BITS    = 48;
    localparam int FUNC_ID_BITS = 32;

    localparam int SP_BITS  = $clog2(STACK_DEPTH);
    localparam int RP_BITS  = $clog2(RECORD_SLOTS);
    localparam int CMD_BITS = 3;
    localparam int STS_BITS = 3;
    localparam int CNT_BITS = 32;
    localparam int TOT_BITS = 64;
    localparam int IDX_BITS = 8;
    localparam int USED_BITS = 9;
    localparam int IN_FID_BITS = 32;
    localparam int IN_TIME_BITS = 48;
    localparam int FRAME_BITS = FUNC_ID_BITS + 1 + 2 * TIME_BITS;
    localparam int REC_BITS = FUNC_ID_BITS + CNT_BITS + TOT_BITS;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CALL   = 3'd0,
        CMD_TAIL   = 3'd1,
        CMD_RETURN = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STS_BITS-1:0] {
        STS_OK         = 3'd0,
        STS_DISABLED   = 3'd1,
        STS_STACK_FULL = 3'd2,
        STS_EMPTY      = 3'd3,
        STS_TABLE_FULL = 3'd4,
        STS_BAD_INDEX  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_RD,
        ST_POP_CALC,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_REC_SUM,
        ST_REC_WR,
        ST_PAR_RD,
        ST_PAR_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic push;
        logic load_in;
        logic pop_rd;
        logic pop_calc;
        logic srch_start;
        logic srch_rd;
        logic srch_next;
        logic rec_sum;
        logic rec_wr;
        logic par_rd;
        logic par_wr;
        logic read_rd;
        logic read_cap;
        logic clear;
        logic set_sts;
        logic [STS_BITS-1:0] sts;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic stack_full;
        logic stack_empty;
        logic has_parent;
        logic tail;
        logic srch_hit;
        logic srch_end;
        logic table_full;
        logic idx_bad;
        logic out_busy;
    } stat_t;

endpackage

### design/cstp_if.sv
interface cstp_in_if;
    logic                          valid;
    logic                          ready;
    logic [cstp_pkg::CMD_BITS-1:0] command;
    logic [31:0]                   func_id;
    logic [47:0]                   timestamp;
    logic [47:0]                   switched_out_time;
    logic [7:0]                    record_index;
    modport source (output valid, command, func_id, timestamp, switched_out_time,
                    record_index, input ready);
    modport sink (input valid, command, func_id, timestamp, switched_out_time,
                  record_index, output ready);
endinterface

interface cstp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] rec_func_id;
    logic [31:0] call_count;
    logic [63:0] total_time;
    logic [8:0]  records_used;
    modport source (output valid, status, rec_func_id, call_count, total_time,
                    records_used, input ready);
    modport sink (input valid, status, rec_func_id, call_count, total_time,
                  records_used, output ready);
endinterface

### design/cstp_ram.sv
module cstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/cstp_ctrl.sv
module cstp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            enable,
    input  cstp_pkg::stat_t st,
    output cstp_pkg::ctrl_t ctl
);

    cstp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cstp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cstp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cstp_pkg::ST_DECODE;
                end
            end
            cstp_pkg::ST_DECODE:
            begin
                case (st.cmd)
                    cstp_pkg::CMD_RETURN:
                    begin
                        if (enable && !st.stack_empty)
                        begin
                            state_next = cstp_pkg::ST_POP_RD;
                        end
                        else
                        begin
                            state_next = cstp_pkg::ST_DONE;
                        end
                    end
                    cstp_pkg::CMD_READ:
                    begin
                        if (st.idx_bad)
                        begin
                            state_next = cstp_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = cstp_pkg::ST_READ_RD;
                        end
                    end
                    default:
                    begin
                        state_next = cstp_pkg::ST_DONE;
                    end
                endcase
            end
            cstp_pkg::ST_POP_RD:    state_next = cstp_pkg::ST_POP_CALC;
            cstp_pkg::ST_POP_CALC:  state_next = cstp_pkg::ST_SRCH_RD;
            cstp_pkg::ST_SRCH_RD:
            begin
                if (st.srch_end)
                begin
                    state_next = cstp_pkg::ST_REC_SUM;
                end
                else
                begin
                    state_next = cstp_pkg::ST_SRCH_CMP;
                end
            end
            cstp_pkg::ST_SRCH_CMP:
            begin
                if (st.srch_hit)
                begin
                    state_next = cstp_pkg::ST_REC_SUM;
                end
                else
                begin
                    state_next = cstp_pkg::ST_SRCH_RD;
                end
            end
            cstp_pkg::ST_REC_SUM:   state_next = cstp_pkg::ST_REC_WR;
            cstp_pkg::ST_REC_WR:
            begin
                if (st.has_parent)
                begin
                    state_next = cstp_pkg::ST_PAR_RD;
                end
                else
                begin
                    state_next = cstp_pkg::ST_DONE;
                end
            end
            cstp_pkg::ST_PAR_RD:    state_next = cstp_pkg::ST_PAR_WR;
            cstp_pkg::ST_PAR_WR:
            begin
                if (st.tail)
                begin
                    state_next = cstp_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = cstp_pkg::ST_DONE;
                end
            end
            cstp_pkg::ST_READ_RD:   state_next = cstp_pkg::ST_READ_WAIT;
            cstp_pkg::ST_READ_WAIT: state_next = cstp_pkg::ST_DONE;
            cstp_pkg::ST_DONE:
            begin
                if (!st.out_busy)
                begin
                    state_next = cstp_pkg::ST_IDLE;
                end
            end
            default:                state_next = cstp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        case (state_reg)
            cstp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load_in = in_valid;
            end
            cstp_pkg::ST_DECODE:
            begin
                ctl.set_sts = 1'b1;
                ctl.sts = cstp_pkg::STS_OK;
                case (st.cmd)
                    cstp_pkg::CMD_CALL, cstp_pkg::CMD_TAIL:
                    begin
                        if (!enable)
                        begin
                            ctl.sts = cstp_pkg::STS_DISABLED;
                        end
                        else if (st.stack_full)
                        begin
                            ctl.sts = cstp_pkg::STS_STACK_FULL;
                        end
                        else
                        begin
                            ctl.push = 1'b1;
                        end
                    end
                    cstp_pkg::CMD_RETURN:
                    begin
                        if (!enable)
                        begin
                            ctl.sts = cstp_pkg::STS_DISABLED;
                        end
                        else if (st.stack_empty)
                        begin
                            ctl.sts = cstp_pkg::STS_EMPTY;
                        end
                    end
                    cstp_pkg::CMD_READ:
                    begin
                        if (st.idx_bad)
                        begin
                            ctl.sts = cstp_pkg::STS_BAD_INDEX;
                        end
                    end
                    cstp_pkg::CMD_CLEAR:
                    begin
                        ctl.clear = 1'b1;
                    end
                    default:
                    begin
                        ctl.sts = cstp_pkg::STS_OK;
                    end
                endcase
            end
            cstp_pkg::ST_POP_RD:   ctl.pop_rd = 1'b1;
            cstp_pkg::ST_POP_CALC:
            begin
                ctl.pop_calc = 1'b1;
                ctl.srch_start = 1'b1;
            end
            cstp_pkg::ST_SRCH_RD:  ctl.srch_rd = 1'b1;
            cstp_pkg::ST_SRCH_CMP: ctl.srch_next = !st.srch_hit;
            cstp_pkg::ST_REC_SUM:
            begin
                ctl.rec_sum = 1'b1;
                if (!st.srch_hit && st.table_full)
                begin
                    ctl.set_sts = 1'b1;
                    ctl.sts = cstp_pkg::STS_TABLE_FULL;
                end
            end
            cstp_pkg::ST_REC_WR:   ctl.rec_wr = 1'b1;
            cstp_pkg::ST_PAR_RD:   ctl.par_rd = 1'b1;
            cstp_pkg::ST_PAR_WR:   ctl.par_wr = 1'b1;
            cstp_pkg::ST_READ_RD:  ctl.read_rd = 1'b1;
            cstp_pkg::ST_READ_WAIT: ctl.read_cap = 1'b1;
            cstp_pkg::ST_DONE:     ctl.emit = !st.out_busy;
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

### design/cstp_dp.sv
module cstp_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               in_command,
    input  logic [31:0]              in_func_id,
    input  logic [47:0]              in_timestamp,
    input  logic [47:0]              in_switched_out_time,
    input  logic [7:0]               in_record_index,
    input  cstp_pkg::ctrl_t          ctl,
    output cstp_pkg::stat_t          st,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_status,
    output logic [31:0]              out_rec_func_id,
    output logic [31:0]              out_call_count,
    output logic [63:0]              out_total_time,
    output logic [8:0]               out_records_used
);

    localparam int SP = cstp_pkg::SP_BITS;
    localparam int RP = cstp_pkg::RP_BITS;
    localparam int TB = cstp_pkg::TIME_BITS;
    localparam int FB = cstp_pkg::FUNC_ID_BITS;

    logic [cstp_pkg::CMD_BITS-1:0] cmd_reg;
    logic [FB-1:0]                 fid_reg;
    logic [TB-1:0]                 now_reg, sw_reg;
    logic [cstp_pkg::IDX_BITS-1:0] idx_reg;
    logic [SP:0]                   depth_reg;
    logic [RP:0]                   used_reg;
    logic [cstp_pkg::STS_BITS-1:0] sts_reg;

    logic [FB-1:0] pop_fid_reg;
    logic          pop_tail_reg;
    logic [TB-1:0] incl_reg, excl_reg;
    logic [RP:0]   srch_reg;
    logic          hit_reg;
    logic [cstp_pkg::CNT_BITS-1:0] cnt_reg;
    logic [cstp_pkg::TOT_BITS-1:0] tot_reg;

    logic [FB-1:0]                 rd_fid_reg;
    logic [cstp_pkg::CNT_BITS-1:0] rd_cnt_reg;
    logic [cstp_pkg::TOT_BITS-1:0] rd_tot_reg;

    logic          out_valid_reg;
    logic [2:0]    o_sts_reg;
    logic [31:0]   o_fid_reg, o_cnt_reg;
    logic [63:0]   o_tot_reg;
    logic [8:0]    o_used_reg;

    logic                           s_we;
    logic [SP-1:0]                  s_waddr, s_raddr;
    logic [cstp_pkg::FRAME_BITS-1:0] s_wdata, s_rdata;
    logic                           r_we;
    logic [RP-1:0]                  r_waddr, r_raddr;
    logic [cstp_pkg::REC_BITS-1:0]  r_wdata, r_rdata;

    logic [FB-1:0]  f_fid;
    logic           f_tail;
    logic [TB-1:0]  f_start, f_child;
    logic [FB-1:0]  rr_fid;
    logic [cstp_pkg::CNT_BITS-1:0] rr_cnt;
    logic [cstp_pkg::TOT_BITS-1:0] rr_tot;
    logic [TB:0]    child_sum, par_sum;
    logic [TB-1:0]  child_sat, incl_now;
    logic [cstp_pkg::TOT_BITS-1:0] tot_base;
    logic [cstp_pkg::TOT_BITS:0] tot_sum;

    assign {f_fid, f_tail, f_start, f_child} = s_rdata;
    assign {rr_fid, rr_cnt, rr_tot} = r_rdata;

    cstp_ram #(.WIDTH(cstp_pkg::FRAME_BITS), .DEPTH(cstp_pkg::STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    cstp_ram #(.WIDTH(cstp_pkg::REC_BITS), .DEPTH(cstp_pkg::RECORD_SLOTS)) u_rec (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    assign child_sum = {1'b0, f_child} + {1'b0, sw_reg};
    assign child_sat = child_sum[TB] ? cstp_pkg::TIME_MAX : child_sum[TB-1:0];
    assign incl_now  = (now_reg > f_start) ? now_reg - f_start : '0;
    assign par_sum   = {1'b0, f_child} + {1'b0, incl_reg};
    assign tot_base  = hit_reg ? rr_tot : '0;
    assign tot_sum   = {1'b0, tot_base} + {{(cstp_pkg::TOT_BITS-TB+1){1'b0}}, excl_reg};

    always_comb
    begin
        s_we = 1'b0;
        s_waddr = depth_reg[SP-1:0];
        s_wdata = {fid_reg, (cmd_reg == cstp_pkg::CMD_TAIL), now_reg, {TB{1'b0}}};
        s_raddr = depth_reg[SP-1:0] - 1'b1;
        if (ctl.push)
        begin
            s_we = 1'b1;
        end
        if (ctl.par_wr)
        begin
            s_we = 1'b1;
            s_waddr = depth_reg[SP-1:0] - 1'b1;
            s_wdata = {f_fid, f_tail, f_start,
                       par_sum[TB] ? cstp_pkg::TIME_MAX : par_sum[TB-1:0]};
        end
    end

    always_comb
    begin
        r_we = ctl.rec_wr && (hit_reg || !used_reg[RP]);
        r_waddr = srch_reg[RP-1:0];
        r_wdata = {pop_fid_reg, cnt_reg, tot_reg};
        r_raddr = ctl.read_rd ? idx_reg[RP-1:0] : srch_reg[RP-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg <= in_command;
            fid_reg <= in_func_id[FB-1:0];
            now_reg <= in_timestamp[TB-1:0];
            sw_reg  <= in_switched_out_time[TB-1:0];
            idx_reg <= in_record_index;
        end
        if (ctl.pop_calc)
        begin
            pop_fid_reg  <= f_fid;
            pop_tail_reg <= f_tail;
            incl_reg     <= incl_now;
            excl_reg     <= (incl_now > child_sat) ? incl_now - child_sat : '0;
        end
        if (ctl.rec_sum)
        begin
            if (hit_reg)
            begin
                cnt_reg <= (rr_cnt == '1) ? rr_cnt : rr_cnt + 1'b1;
            end
            else
            begin
                cnt_reg <= 32'd1;
            end
            tot_reg <= tot_sum[cstp_pkg::TOT_BITS] ? '1 : tot_sum[cstp_pkg::TOT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            used_reg  <= '0;
            sts_reg   <= '0;
            srch_reg  <= '0;
            hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_sts)
            begin
                sts_reg <= ctl.sts;
            end
            if (ctl.push)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            if (ctl.pop_rd)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (ctl.clear)
            begin
                depth_reg <= '0;
                used_reg  <= '0;
            end
            if (ctl.srch_start)
            begin
                srch_reg <= '0;
                hit_reg  <= 1'b0;
            end
            if (ctl.srch_next)
            begin
                srch_reg <= srch_reg + 1'b1;
            end
            if (ctl.srch_rd && !st.srch_end)
            begin
                hit_reg <= 1'b0;
            end
            if (ctl.srch_next == 1'b0 && st.srch_hit == 1'b0 && ctl.srch_rd == 1'b0
                && ctl.srch_start == 1'b0 && ctl.rec_sum == 1'b0 && ctl.rec_wr == 1'b0
                && hit_reg)
            begin
                hit_reg <= 1'b0;
            end
            if (!ctl.srch_rd && !ctl.srch_start && rr_fid == pop_fid_reg
                && ctl.srch_next == 1'b0 && st.srch_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (ctl.rec_wr && !hit_reg && !used_reg[RP])
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read_cap)
        begin
            rd_fid_reg <= rr_fid;
            rd_cnt_reg <= rr_cnt;
            rd_tot_reg <= rr_tot;
        end
        if (ctl.load_in)
        begin
            rd_fid_reg <= '0;
            rd_cnt_reg <= '0;
            rd_tot_reg <= '0;
        end
        if (ctl.emit)
        begin
            o_fid_reg  <= 32'(rd_fid_reg);
            o_cnt_reg  <= rd_cnt_reg;
            o_tot_reg  <= rd_tot_reg;
            o_sts_reg  <= sts_reg;
            o_used_reg <= 9'(used_reg);
        end
    end

    always_comb
    begin
        st.cmd         = cmd_reg;
        st.stack_full  = depth_reg[SP];
        st.stack_empty = (depth_reg == '0);
        st.has_parent  = (depth_reg != '0);
        st.tail        = pop_tail_reg;
        st.srch_end    = (srch_reg == used_reg);
        st.srch_hit    = hit_reg || (rr_fid == pop_fid_reg && !st.srch_end);
        st.table_full  = used_reg[RP];
        st.idx_bad     = ({{(RP+1>8 ? RP+1-8 : 0){1'b0}}, idx_reg} >= used_reg);
        st.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = o_sts_reg;
    assign out_rec_func_id  = o_fid_reg;
    assign out_call_count   = o_cnt_reg;
    assign out_total_time   = o_tot_reg;
    assign out_records_used = o_used_reg;

endmodule

### design/call_stack_exclusive_time_profiler_top.sv
// one request at a time, from acceptance to the next ready; a return pops a
// frame, walks the record table in memory comparing each record, writes the
// record and, for a frame with a parent, updates the parent frame, then pops
// again while the popped frame was a tail call; results go out through an
// output register and a held result stalls only the end of the next request
module call_stack_exclusive_time_profiler_top (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    cstp_in_if.sink    req,
    cstp_out_if.source rsp
);

    logic            enable_reg;
    cstp_pkg::ctrl_t ctl;
    cstp_pkg::stat_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    cstp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .enable(enable_reg), .st(st), .ctl(ctl)
    );

    cstp_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_command(req.command), .in_func_id(req.func_id),
        .in_timestamp(req.timestamp), .in_switched_out_time(req.switched_out_time),
        .in_record_index(req.record_index),
        .ctl(ctl), .st(st),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .out_status(rsp.status), .out_rec_func_id(rsp.rec_func_id),
        .out_call_count(rsp.call_count), .out_total_time(rsp.total_time),
        .out_records_used(rsp.records_used)
    );

endmodule

### design/cstp_checker.sv
module cstp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic [8:0] rsp_records_used
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= cstp_pkg::STS_BAD_INDEX) else $error("status out of range");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_records_used <= 9'(cstp_pkg::RECORD_SLOTS))
        else $error("records_used too big");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready) else $error("accepted twice");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");

endmodule

bind call_stack_exclusive_time_profiler_top cstp_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_records_used(rsp.records_used)
);

### tb/cstp_checker.sv
`timescale 1ns / 1ps

module cstp_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    cstp_in_if          req,
    cstp_out_if         rsp,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rec_func_id;
        logic [31:0] call_count;
        logic [63:0] total_time;
        logic [8:0]  records_used;
    } result_t;

    logic [31:0] frame_fid   [cstp_pkg::STACK_DEPTH];
    logic        frame_tail  [cstp_pkg::STACK_DEPTH];
    logic [47:0] frame_start [cstp_pkg::STACK_DEPTH];
    logic [47:0] frame_child [cstp_pkg::STACK_DEPTH];
    int          depth;
    logic [31:0] rec_fid   [cstp_pkg::RECORD_SLOTS];
    logic [31:0] rec_calls [cstp_pkg::RECORD_SLOTS];
    logic [63:0] rec_sum   [cstp_pkg::RECORD_SLOTS];
    int          nrec;
    logic        profiling_on;
    result_t     expected_results[$];

    function automatic logic [47:0] add_time_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? cstp_pkg::TIME_MAX : s[47:0];
    endfunction

    function automatic logic [47:0] sub_sat(logic [47:0] a, logic [47:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic bit charge_record(logic [31:0] fid, logic [47:0] cost);
        int i;
        logic [64:0] s;
        for (i = 0; i < nrec; i++)
            if (rec_fid[i] == fid)
                break;
        if (i >= nrec)
        begin
            if (nrec >= cstp_pkg::RECORD_SLOTS)
                return 0;
            i = nrec++;
            rec_fid[i] = fid;
            rec_calls[i] = '0;
            rec_sum[i] = '0;
        end
        if (rec_calls[i] != 32'hFFFF_FFFF)
            rec_calls[i]++;
        s = {1'b0, rec_sum[i]} + {17'b0, cost};
        rec_sum[i] = s[64] ? '1 : s[63:0];
        return 1;
    endfunction

    function automatic result_t profile_event(logic [2:0] cmd, logic [31:0] fid,
                                              logic [47:0] now, logic [47:0] sw,
                                              logic [7:0] idx);
        result_t r;
        bit more;
        int d;
        logic [47:0] child, incl, excl;
        r = '0;
        r.status = cstp_pkg::STS_OK;
        if (cmd == cstp_pkg::CMD_CALL || cmd == cstp_pkg::CMD_TAIL)
        begin
            if (!profiling_on)
                r.status = cstp_pkg::STS_DISABLED;
            else if (depth >= cstp_pkg::STACK_DEPTH)
                r.status = cstp_pkg::STS_STACK_FULL;
            else
            begin
                frame_fid[depth] = fid;
                frame_tail[depth] = (cmd == cstp_pkg::CMD_TAIL);
                frame_start[depth] = now;
                frame_child[depth] = '0;
                depth++;
            end
        end
        else if (cmd == cstp_pkg::CMD_RETURN)
        begin
            if (!profiling_on)
                r.status = cstp_pkg::STS_DISABLED;
            else if (depth == 0)
                r.status = cstp_pkg::STS_EMPTY;
            else
            begin
                do
                begin
                    depth--;
                    d = depth;
                    child = add_time_sat(frame_child[d], sw);
                    incl = sub_sat(now, frame_start[d]);
                    excl = sub_sat(incl, child);
                    if (!charge_record(frame_fid[d], excl))
                        r.status = cstp_pkg::STS_TABLE_FULL;
                    more = 0;
                    if (depth > 0)
                    begin
                        frame_child[d-1] = add_time_sat(frame_child[d-1], incl);
                        more = frame_tail[d];
                    end
                end
                while (more);
            end
        end
        else if (cmd == cstp_pkg::CMD_READ)
        begin
            if (idx < nrec)
            begin
                r.rec_func_id = rec_fid[idx];
                r.call_count = rec_calls[idx];
                r.total_time = rec_sum[idx];
            end
            else
                r.status = cstp_pkg::STS_BAD_INDEX;
        end
        else if (cmd == cstp_pkg::CMD_CLEAR)
        begin
            depth = 0;
            nrec = 0;
        end
        r.records_used = nrec[8:0];
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n)
        begin
            depth = 0;
            nrec = 0;
            profiling_on = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                profiling_on = cfg_wdata;
            if (req.valid && req.ready)
                expected_results.push_back(profile_event(req.command, req.func_id,
                    req.timestamp, req.switched_out_time, req.record_index));
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.rec_func_id, rsp.call_count, rsp.total_time,
                       rsp.records_used};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: sts %0d/%0d fid %h/%h cnt %0d/%0d",
                                      " tot %0d/%0d used %0d/%0d"},
                                     want.status, got.status, want.rec_func_id,
                                     got.rec_func_id, want.call_count, got.call_count,
                                     want.total_time, got.total_time,
                                     want.records_used, got.records_used);
                    end
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [47:0] ALL_TIME = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    bit   quiet;
    bit   hold_go;
    bit   hold;
    logic [47:0] clock_ns;

    cstp_in_if  req_if();
    cstp_out_if rsp_if();

    call_stack_exclusive_time_profiler_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req_if), .rsp(rsp_if)
    );

    cstp_scoreboard chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req_if), .rsp(rsp_if), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (hold)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= quiet || ($urandom_range(99) >= 6);
    end

    initial
    begin
        hold = 0;
        wait (hold_go);
        @(posedge clk);
        hold = 1;
        repeat (300) @(posedge clk);
        hold = 0;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL call_stack_exclusive_time_profiler_top");
        $finish;
    end

    task automatic send(logic [2:0] cmd, logic [31:0] fid, logic [47:0] ts,
                        logic [47:0] sw, logic [7:0] idx);
        while (!quiet && $urandom_range(99) < 6)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.func_id <= fid;
        req_if.timestamp <= ts;
        req_if.switched_out_time <= sw;
        req_if.record_index <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic set_enable(logic value);
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic tick(int step);
        clock_ns = clock_ns + 48'(step);
    endtask

    task automatic random_phase(int count);
        int roll;
        logic [31:0] fid;
        logic [47:0] sw;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            fid = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(11);
            tick($urandom_range(200));
            if ($urandom_range(29) == 0)
                clock_ns = 48'({$urandom(), $urandom()});
            sw = ($urandom_range(9) == 0) ? 48'({$urandom(), $urandom()})
                                          : 48'($urandom_range(15));
            if (roll < 38)
                send(cstp_pkg::CMD_CALL, fid, clock_ns, sw, 8'($urandom()));
            else if (roll < 52)
                send(cstp_pkg::CMD_TAIL, fid, clock_ns, sw, 8'($urandom()));
            else if (roll < 84)
                send(cstp_pkg::CMD_RETURN, fid, clock_ns, sw, 8'($urandom()));
            else if (roll < 96)
                send(cstp_pkg::CMD_READ, fid, clock_ns, sw,
                     $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom_range(255)));
            else if (roll < 98)
                send(cstp_pkg::CMD_CLEAR, $urandom(), clock_ns, sw, 8'($urandom()));
            else
                send(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), $urandom(),
                     48'({$urandom(), $urandom()}), sw, 8'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        quiet = 0;
        hold_go = 0;
        clock_ns = '0;
        req_if.valid = 1'b0;
        req_if.command = cstp_pkg::CMD_CALL;
        req_if.func_id = '0;
        req_if.timestamp = '0;
        req_if.switched_out_time = '0;
        req_if.record_index = '0;
        rsp_if.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled, empty reads, clear and spare codes
        send(cstp_pkg::CMD_CALL, 32'd7, 48'd10, '0, '0);
        send(cstp_pkg::CMD_RETURN, 32'd7, 48'd20, '0, '0);
        send(cstp_pkg::CMD_READ, '0, '0, '0, 8'd0);
        send(cstp_pkg::CMD_CLEAR, '0, '0, '0, '0);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send(c[2:0], '1, ALL_TIME, ALL_TIME, '1);
        set_enable(1'b1);
        send(cstp_pkg::CMD_RETURN, '0, 48'd50, '0, '0);
        send(cstp_pkg::CMD_CALL, 32'hA, 48'd100, '0, '0);
        send(cstp_pkg::CMD_CALL, 32'hB, 48'd150, '0, '0);
        send(cstp_pkg::CMD_TAIL, 32'hC, 48'd160, '0, '0);
        send(cstp_pkg::CMD_RETURN, '0, 48'd200, 48'd5, '0);
        send(cstp_pkg::CMD_RETURN, '0, 48'd300, '0, '0);
        send(cstp_pkg::CMD_CALL, '1, ALL_TIME, '0, '0);
        send(cstp_pkg::CMD_RETURN, '0, 48'd0, '0, '0);
        send(cstp_pkg::CMD_CALL, '0, 48'd0, '0, '0);
        send(cstp_pkg::CMD_CALL, 32'd1, 48'd10, '0, '0);
        send(cstp_pkg::CMD_RETURN, '0, 48'd20, ALL_TIME, '0);
        send(cstp_pkg::CMD_RETURN, '0, ALL_TIME, '0, '0);
        for (int i = 0; i < 5; i++)
            send(cstp_pkg::CMD_READ, '0, '0, '0, i[7:0]);
        send(cstp_pkg::CMD_READ, '1, '0, '0, 8'd255);
        send(cstp_pkg::CMD_CLEAR, '0, '0, '0, '0);

        // long tail-call chain popped by one return overflows the record table
        quiet = 1;
        send(cstp_pkg::CMD_CALL, 32'd1000, 48'd10, '0, '0);
        for (int i = 1; i <= cstp_pkg::RECORD_SLOTS; i++)
            send(cstp_pkg::CMD_TAIL, 32'd1000 + 32'(i), 48'd10 + 48'(i), '0, '0);
        send(cstp_pkg::CMD_RETURN, '0, 48'd5000, '0, '0);
        send(cstp_pkg::CMD_READ, '0, '0, '0, 8'd255);
        send(cstp_pkg::CMD_CLEAR, '0, '0, '0, '0);
        quiet = 0;

        hold_go = 1;
        random_phase(120);
        set_enable(1'b0);
        random_phase(30);
        set_enable(1'b1);
        random_phase(110);

        req_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("PASS call_stack_exclusive_time_profiler_top");
        else
            $display("FAIL call_stack_exclusive_time_profiler_top");
        $finish;
    end

endmodule
